### hw/rtl/first_fit_heap_allocator_macros.svh
// Assertion macros for the first-fit heap allocator.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define FFHA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FFHA_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FFHA_ASSERT(label, clk, rst_n, prop, msg)
`define FFHA_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

### hw/rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Shared widths, status codes and the block table entry type.
// ----------------------------------------------------------------------------
package ffha_pkg;
  localparam int unsigned MaxBlocks   = 64;
  localparam int unsigned SlotW       = $clog2(MaxBlocks);
  localparam int unsigned UnitW       = 12;
  localparam int unsigned TopW        = 13;
  localparam int unsigned AddrW       = 15;
  localparam int unsigned UnitShift   = 3;
  localparam int unsigned HeaderUnits = 3;
  localparam int unsigned ArenaUnits  = 4096;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoSpace = 2'd1;
  localparam logic [1:0] StZero    = 2'd2;
  localparam logic [1:0] StBadFree = 2'd3;

  typedef struct packed {
    logic [UnitW-1:0] start;
    logic [UnitW-1:0] units;
    logic             is_free;
    logic [SlotW-1:0] next;
    logic             has_next;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [SlotW-1:0] waddr;
    entry_t           wdata;
    logic [SlotW-1:0] raddr;
  } tbl_req_t;
endpackage

### hw/rtl/ffha_table.sv
// ----------------------------------------------------------------------------
// Block table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffha_table
  import ffha_pkg::*;
(
  input  logic     clk_i,
  input  tbl_req_t req_i,
  output entry_t   rdata_o
);
  entry_t mem_q [MaxBlocks];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem_q[req_i.raddr];
  end
endmodule

### hw/rtl/ffha_slots.sv
// ----------------------------------------------------------------------------
// Slot occupancy tracker
// Holds one in-use bit per table slot and finds the lowest free slot.
// ----------------------------------------------------------------------------
module ffha_slots
  import ffha_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             set_i,
  input  logic [SlotW-1:0] set_slot_i,
  input  logic             clr_i,
  input  logic [SlotW-1:0] clr_slot_i,
  output logic             free_ok_o,
  output logic [SlotW-1:0] free_slot_o
);
  logic [MaxBlocks-1:0] used_q, used_d;

  always_comb begin
    used_d = used_q;
    if (clr_i) begin
      used_d[clr_slot_i] = 1'b0;
    end
    if (set_i) begin
      used_d[set_slot_i] = 1'b1;
    end
  end

  always_comb begin
    free_ok_o   = 1'b0;
    free_slot_o = '0;
    for (int i = MaxBlocks - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_ok_o   = 1'b1;
        free_slot_o = SlotW'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end
endmodule

### hw/rtl/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator
// Address-ordered block list held in a table memory, walked by a sequencer.
// ----------------------------------------------------------------------------
// One request is taken at a time. An allocate walks the block list, reading
// each visited block from the table and checking it when the registered read
// data returns. A fit that splits writes the remainder as a new free block, and
// an append writes the new block and, if the list was not empty, reads and
// patches the tail link. A free walks to the block and then makes a second
// merging pass over the list from the head. The result is held in an output
// register, and the next request is taken as soon as the result has been
// delivered.
`include "first_fit_heap_allocator_macros.svh"
module first_fit_heap_allocator
  import ffha_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [12:0]      cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             op_i,
  input  logic [AddrW-1:0] request_bytes_i,
  input  logic [AddrW-1:0] payload_address_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [AddrW-1:0] result_address_o,
  output logic [1:0]       status_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_A_RD, S_A_CHK, S_A_SPLIT, S_A_APP,
    S_F_RD, S_F_CHK, S_M_RD, S_M_CUR, S_M_NRD, S_M_NCHK, S_DONE
  } state_e;

  state_e           state_q;
  logic [12:0]      limit_q;
  logic [SlotW:0]   head_q;
  logic [TopW-1:0]  top_q;
  logic             op_q;
  logic [UnitW:0]   units_q;
  logic [AddrW-1:0] addr_q;
  logic [SlotW-1:0] cur_q, last_q, nx_q;
  logic             has_last_q;
  logic [SlotW:0]   steps_q;
  entry_t           cur_e_q;
  logic [AddrW-1:0] res_addr_q;
  logic [1:0]       res_st_q;

  tbl_req_t         treq, treq_mux;
  entry_t           rdata;
  logic             s_set, s_clr, s_ok;
  logic [SlotW-1:0] s_set_slot, s_clr_slot, s_free;

  ffha_table u_table (.clk_i(clk_i), .req_i(treq_mux), .rdata_o(rdata));
  ffha_slots u_slots (
    .clk_i(clk_i), .rst_ni(rst_ni), .set_i(s_set), .set_slot_i(s_set_slot),
    .clr_i(s_clr), .clr_slot_i(s_clr_slot), .free_ok_o(s_ok), .free_slot_o(s_free)
  );

  logic [13:0]      lim_eff;
  logic [UnitW-1:0] pay_units;
  logic [AddrW-1:0] pay_addr;
  logic [UnitW:0]   excess;
  logic [14:0]      app_end;

  assign lim_eff   = (limit_q < 13'(ArenaUnits)) ? {1'b0, limit_q} : 14'(ArenaUnits);
  assign pay_units = rdata.start + UnitW'(HeaderUnits);
  assign pay_addr  = AddrW'({pay_units, {UnitShift{1'b0}}});
  assign excess    = {1'b0, rdata.units} - units_q;
  assign app_end   = 15'(top_q) + 15'(HeaderUnits) + 15'(units_q);

  assign cfg_ready_o      = (state_q == S_IDLE);
  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = (state_q == S_DONE);
  assign result_address_o = res_addr_q;
  assign status_o         = res_st_q;

  always_comb begin
    treq       = '0;
    treq.raddr = cur_q;
    s_set      = 1'b0;
    s_set_slot = s_free;
    s_clr      = 1'b0;
    s_clr_slot = nx_q;
    case (state_q)
      S_M_NRD: treq.raddr = nx_q;
      S_A_CHK: begin
        if (rdata.is_free && units_q <= {1'b0, rdata.units}) begin
          treq.we    = 1'b1;
          treq.waddr = cur_q;
          treq.wdata = rdata;
          treq.wdata.is_free = 1'b0;
          if (excess > (UnitW+1)'(HeaderUnits) && s_ok) begin
            treq.wdata.units    = units_q[UnitW-1:0];
            treq.wdata.next     = s_free;
            treq.wdata.has_next = 1'b1;
          end
        end
      end
      S_A_SPLIT: begin
        treq.we             = 1'b1;
        treq.waddr          = s_free;
        treq.wdata.start    = cur_e_q.start + UnitW'(HeaderUnits) + units_q[UnitW-1:0];
        treq.wdata.units    = cur_e_q.units - UnitW'(HeaderUnits) - units_q[UnitW-1:0];
        treq.wdata.is_free  = 1'b1;
        treq.wdata.next     = cur_e_q.next;
        treq.wdata.has_next = cur_e_q.has_next;
        s_set               = 1'b1;
      end
      S_A_APP: begin
        if (s_ok && app_end <= 15'(lim_eff)) begin
          treq.we          = 1'b1;
          treq.waddr       = s_free;
          treq.wdata.start = top_q[UnitW-1:0];
          treq.wdata.units = units_q[UnitW-1:0];
          s_set            = 1'b1;
        end
      end
      S_F_CHK: begin
        if (pay_addr == addr_q && !rdata.is_free) begin
          treq.we            = 1'b1;
          treq.waddr         = cur_q;
          treq.wdata         = rdata;
          treq.wdata.is_free = 1'b1;
        end
      end
      S_M_NCHK: begin
        if (cur_e_q.is_free && rdata.is_free) begin
          treq.we             = 1'b1;
          treq.waddr          = cur_q;
          treq.wdata          = cur_e_q;
          treq.wdata.units    = cur_e_q.units + rdata.units + UnitW'(HeaderUnits);
          treq.wdata.next     = rdata.next;
          treq.wdata.has_next = rdata.has_next;
          s_clr               = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      limit_q    <= 13'd4096;
      head_q     <= (SlotW+1)'(MaxBlocks);
      top_q      <= '0;
      op_q       <= OpAlloc;
      units_q    <= '0;
      addr_q     <= '0;
      cur_q      <= '0;
      last_q     <= '0;
      nx_q       <= '0;
      has_last_q <= 1'b0;
      steps_q    <= '0;
      cur_e_q    <= '0;
      res_addr_q <= '0;
      res_st_q   <= StOk;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cfg_valid_i) begin
            limit_q <= cfg_data_i;
          end
          if (in_valid_i) begin
            op_q       <= op_i;
            addr_q     <= payload_address_i;
            units_q    <= (UnitW+1)'((16'(request_bytes_i) + 16'(7)) >> UnitShift);
            cur_q      <= head_q[SlotW-1:0];
            has_last_q <= 1'b0;
            steps_q    <= '0;
            res_addr_q <= '0;
            res_st_q   <= StOk;
            if (op_i == OpAlloc) begin
              if (request_bytes_i == '0) begin
                res_st_q <= StZero;
                state_q  <= S_DONE;
              end else begin
                state_q <= head_q[SlotW] ? S_A_APP : S_A_RD;
              end
            end else if (payload_address_i == '0) begin
              state_q <= S_DONE;
            end else if (head_q[SlotW]) begin
              res_st_q <= StBadFree;
              state_q  <= S_DONE;
            end else begin
              state_q <= S_F_RD;
            end
          end
        end
        S_A_RD: state_q <= S_A_CHK;
        S_A_CHK: begin
          cur_e_q <= rdata;
          if (rdata.is_free && units_q <= {1'b0, rdata.units}) begin
            res_addr_q <= pay_addr;
            state_q    <= (excess > (UnitW+1)'(HeaderUnits) && s_ok) ? S_A_SPLIT : S_DONE;
          end else begin
            last_q     <= cur_q;
            has_last_q <= 1'b1;
            steps_q    <= steps_q + (SlotW+1)'(1);
            if (rdata.has_next && steps_q < (SlotW+1)'(MaxBlocks - 1)) begin
              cur_q   <= rdata.next;
              state_q <= S_A_RD;
            end else begin
              state_q <= S_A_APP;
            end
          end
        end
        S_A_SPLIT: state_q <= S_DONE;
        S_A_APP: begin
          if (s_ok && app_end <= 15'(lim_eff)) begin
            top_q      <= app_end[TopW-1:0];
            res_addr_q <= AddrW'({top_q[UnitW-1:0] + UnitW'(HeaderUnits), {UnitShift{1'b0}}});
            if (has_last_q) begin
              cur_q   <= last_q;
              nx_q    <= s_free;
              state_q <= S_M_RD;
              op_q    <= OpAlloc;
            end else begin
              head_q  <= {1'b0, s_free};
              state_q <= S_DONE;
            end
          end else begin
            res_st_q <= StNoSpace;
            state_q  <= S_DONE;
          end
        end
        S_F_RD: state_q <= S_F_CHK;
        S_F_CHK: begin
          steps_q <= steps_q + (SlotW+1)'(1);
          if (pay_addr == addr_q) begin
            if (rdata.is_free) begin
              res_st_q <= StBadFree;
              state_q  <= S_DONE;
            end else begin
              cur_q   <= head_q[SlotW-1:0];
              steps_q <= '0;
              state_q <= S_M_RD;
            end
          end else if (rdata.has_next && steps_q < (SlotW+1)'(MaxBlocks - 1)) begin
            cur_q   <= rdata.next;
            state_q <= S_F_RD;
          end else begin
            res_st_q <= StBadFree;
            state_q  <= S_DONE;
          end
        end
        S_M_RD: state_q <= S_M_CUR;
        S_M_CUR: begin
          // On an append the tail link is patched; otherwise a merge step.
          if (op_q == OpAlloc) begin
            cur_e_q <= rdata;
            state_q <= S_M_NRD;
          end else begin
            cur_e_q <= rdata;
            if (rdata.has_next) begin
              nx_q    <= rdata.next;
              state_q <= S_M_NRD;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_M_NRD: begin
          if (op_q == OpAlloc) begin
            state_q <= S_DONE;
          end else begin
            state_q <= S_M_NCHK;
          end
        end
        S_M_NCHK: begin
          if (cur_e_q.is_free && rdata.is_free) begin
            cur_e_q.units    <= cur_e_q.units + rdata.units + UnitW'(HeaderUnits);
            cur_e_q.next     <= rdata.next;
            cur_e_q.has_next <= rdata.has_next;
            if (rdata.has_next) begin
              nx_q    <= rdata.next;
              state_q <= S_M_NRD;
            end else begin
              state_q <= S_DONE;
            end
          end else begin
            cur_q   <= nx_q;
            cur_e_q <= rdata;
            if (rdata.has_next) begin
              nx_q    <= rdata.next;
              state_q <= S_M_NRD;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!out_stall_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Tail link write for an append, done while the merge path idles.
  logic tail_we;
  assign tail_we = (state_q == S_M_NRD) && (op_q == OpAlloc);

  entry_t tail_e;
  always_comb begin
    tail_e          = cur_e_q;
    tail_e.next     = nx_q;
    tail_e.has_next = 1'b1;
  end

  always_comb begin
    treq_mux = treq;
    if (tail_we) begin
      treq_mux.we    = 1'b1;
      treq_mux.waddr = cur_q;
      treq_mux.wdata = tail_e;
    end
  end

  `FFHA_ASSERT(a_out_only_done, clk_i, rst_ni, out_valid_o |-> in_stall_o, "output while idle")
  `FFHA_ASSERT(a_top_in_arena, clk_i, rst_ni, 1'b1 |-> top_q <= TopW'(ArenaUnits), "top overflow")
  `FFHA_ASSERT_NEVER(a_split_slot, clk_i, rst_ni, (state_q == S_A_SPLIT) && !s_ok, "split without slot")
endmodule

### dv/tb_first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit heap allocator testbench
// Drives allocate and free requests with random idle and stall, predicts each
// granted address and status with an internal heap model, and checks results.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  typedef struct packed {
    logic             op;
    logic [AddrW-1:0] req_bytes;
    logic [AddrW-1:0] pay_addr;
  } heap_req_t;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [1:0]       status;
  } heap_rsp_t;

  localparam int WatchdogLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [12:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic op_i = 1'b0;
  logic [AddrW-1:0] request_bytes_i = '0;
  logic [AddrW-1:0] payload_address_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [AddrW-1:0] result_address_o;
  logic [1:0] status_o;

  first_fit_heap_allocator DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Heap shadow state.
  int unsigned limit_units;
  int unsigned blk_start [MaxBlocks];
  int unsigned blk_units [MaxBlocks];
  bit blk_free [MaxBlocks];
  int unsigned blk_next [MaxBlocks];
  bit blk_has_next [MaxBlocks];
  bit slot_used [MaxBlocks];
  int unsigned head_slot;
  int unsigned top_units;

  heap_req_t pending_reqs[$];
  heap_rsp_t expected_rsps[$];
  logic [AddrW-1:0] live_addrs[$];
  int send_idle_pct;
  int recv_stall_pct;
  int mismatches;
  int rsp_count;
  int alloc_ok_count;
  int free_ok_count;
  int idle_cycles;
  bit timed_out;

  function automatic int unsigned next_of(int unsigned s);
    return blk_has_next[s] ? blk_next[s] : MaxBlocks;
  endfunction

  function automatic int unsigned first_unused();
    for (int unsigned i = 0; i < MaxBlocks; i++) begin
      if (!slot_used[i]) return i;
    end
    return MaxBlocks;
  endfunction

  function automatic logic [AddrW-1:0] payload_addr(int unsigned s);
    return AddrW'((blk_start[s] + HeaderUnits) << UnitShift);
  endfunction

  function automatic heap_rsp_t heap_alloc(int unsigned nbytes);
    heap_rsp_t r;
    int unsigned units, lim, cur, last, slot;
    r = '0;
    if (nbytes == 0) begin
      r.status = StZero;
      return r;
    end
    units = (nbytes + 7) >> UnitShift;
    lim = limit_units < ArenaUnits ? limit_units : ArenaUnits;
    cur = head_slot;
    last = MaxBlocks;
    for (int steps = 0; steps < MaxBlocks && cur < MaxBlocks; steps++) begin
      if (blk_free[cur] && units <= blk_units[cur]) begin
        blk_free[cur] = 1'b0;
        if (blk_units[cur] - units > HeaderUnits) begin
          slot = first_unused();
          if (slot < MaxBlocks) begin
            slot_used[slot] = 1'b1;
            blk_start[slot] = blk_start[cur] + HeaderUnits + units;
            blk_units[slot] = blk_units[cur] - HeaderUnits - units;
            blk_free[slot] = 1'b1;
            blk_next[slot] = blk_next[cur];
            blk_has_next[slot] = blk_has_next[cur];
            blk_next[cur] = slot;
            blk_has_next[cur] = 1'b1;
            blk_units[cur] = units;
          end
        end
        r.addr = payload_addr(cur);
        return r;
      end
      last = cur;
      cur = next_of(cur);
    end
    slot = first_unused();
    if (slot == MaxBlocks || top_units + HeaderUnits + units > lim) begin
      r.status = StNoSpace;
      return r;
    end
    slot_used[slot] = 1'b1;
    blk_start[slot] = top_units;
    blk_units[slot] = units;
    blk_free[slot] = 1'b0;
    blk_next[slot] = 0;
    blk_has_next[slot] = 1'b0;
    if (last < MaxBlocks) begin
      blk_next[last] = slot;
      blk_has_next[last] = 1'b1;
    end else begin
      head_slot = slot;
    end
    top_units += HeaderUnits + units;
    r.addr = payload_addr(slot);
    return r;
  endfunction

  function automatic heap_rsp_t heap_free(logic [AddrW-1:0] addr);
    heap_rsp_t r;
    int unsigned cur, nx;
    int steps;
    r = '0;
    if (addr == 0) return r;
    cur = head_slot;
    for (steps = 0; steps < MaxBlocks && cur < MaxBlocks; steps++) begin
      if (payload_addr(cur) == addr) break;
      cur = next_of(cur);
    end
    if (cur >= MaxBlocks || steps >= MaxBlocks || blk_free[cur]) begin
      r.status = StBadFree;
      return r;
    end
    blk_free[cur] = 1'b1;
    cur = head_slot;
    for (steps = 0; steps < 2 * MaxBlocks && cur < MaxBlocks; steps++) begin
      nx = next_of(cur);
      if (nx >= MaxBlocks) break;
      if (blk_free[cur] && blk_free[nx]) begin
        blk_units[cur] += blk_units[nx] + HeaderUnits;
        blk_next[cur] = blk_next[nx];
        blk_has_next[cur] = blk_has_next[nx];
        slot_used[nx] = 1'b0;
      end else begin
        cur = nx;
      end
    end
    return r;
  endfunction

  // Driver: the request is predicted when it is accepted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      heap_req_t q;
      heap_rsp_t e;
      if (in_valid_i && !in_stall_o) begin
        q = pending_reqs.pop_front();
        if (q.op == OpAlloc) begin
          e = heap_alloc(q.req_bytes);
          if (e.status == StOk) begin
            live_addrs.push_back(e.addr);
            alloc_ok_count++;
          end
        end else begin
          e = heap_free(q.pay_addr);
          if (e.status == StOk && q.pay_addr != 0) free_ok_count++;
        end
        expected_rsps.push_back(e);
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          op_i <= pending_reqs[0].op;
          request_bytes_i <= pending_reqs[0].req_bytes;
          payload_address_i <= pending_reqs[0].pay_addr;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      heap_rsp_t e;
      if (out_valid_o && !out_stall_i) begin
        rsp_count++;
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result: addr %0d status %0d",
                                         result_address_o, status_o);
        end else begin
          e = expected_rsps.pop_front();
          if (e.addr !== result_address_o || e.status !== status_o) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch: expected addr %0d status %0d, got addr %0d status %0d",
                       e.addr, e.status, result_address_o, status_o);
            end
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) timed_out = 1'b1;
    end
  end

  task automatic push_alloc(int unsigned nbytes);
    pending_reqs.push_back('{OpAlloc, AddrW'(nbytes), AddrW'($urandom)});
  endtask

  task automatic push_free(logic [AddrW-1:0] addr);
    pending_reqs.push_back('{OpFree, AddrW'($urandom), addr});
  endtask

  task automatic drain_and_wait();
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0) begin
      @(posedge clk_i);
      if (timed_out) begin
        $display("TB_ERROR");
        $finish;
      end
    end
    repeat (600) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [12:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    limit_units = value;
    cfg_valid_i <= 1'b0;
  endtask

  // A random mix: mostly allocations of small sizes and frees of live blocks.
  task automatic random_burst(int n);
    int k;
    int unsigned pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 48) begin
        k = $urandom_range(99);
        if (k < 80) push_alloc($urandom_range(1, 200));
        else if (k < 95) push_alloc($urandom_range(1, 2000));
        else push_alloc($urandom_range(0, 32767));
      end else if (pick < 90) begin
        if (live_addrs.size() > 0) begin
          k = $urandom_range(live_addrs.size() - 1);
          push_free(live_addrs[k]);
          live_addrs.delete(k);
        end else begin
          push_alloc($urandom_range(1, 64));
        end
      end else if (pick < 97) begin
        push_free(AddrW'($urandom));
      end else begin
        push_alloc(0);
      end
    end
  endtask

  initial begin
    limit_units = 4096;
    for (int i = 0; i < MaxBlocks; i++) begin
      blk_start[i] = 0; blk_units[i] = 0; blk_free[i] = 0;
      blk_next[i] = 0; blk_has_next[i] = 0; slot_used[i] = 0;
    end
    head_slot = MaxBlocks;
    top_units = 0;
    send_idle_pct = 7;
    recv_stall_pct = 81;
    mismatches = 0;
    rsp_count = 0;
    alloc_ok_count = 0;
    free_ok_count = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero size, aligned and unaligned sizes, split, merge,
    // null, bad and double free, and the largest request.
    push_alloc(0);
    push_alloc(8);
    push_alloc(1);
    push_alloc(200);
    push_alloc(32767);
    push_free(AddrW'(24));
    push_free(AddrW'(24));
    push_free(AddrW'(0));
    push_free(AddrW'(25));
    push_free(AddrW'(32767));
    push_free(AddrW'(56));
    push_free(AddrW'(88));
    push_alloc(16);
    push_alloc(9);
    push_alloc(24);
    push_alloc(7);
    push_alloc(32760);
    drain_and_wait();

    // Split without a free slot and exhaustion of the block table.
    write_limit(13'd4096);
    for (int i = 0; i < 66; i++) push_alloc(8);
    drain_and_wait();
    live_addrs.delete();
    for (int i = 1; i < 60; i += 2) push_free(AddrW'((i * 4 + HeaderUnits) << UnitShift));
    drain_and_wait();

    write_limit(13'd0);
    push_alloc(1);
    push_alloc(100);
    drain_and_wait();
    write_limit(13'd8191);
    random_burst(600);
    drain_and_wait();

    send_idle_pct = 81;
    recv_stall_pct = 7;
    write_limit(13'd300);
    random_burst(400);
    drain_and_wait();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_limit(13'd4095);
    random_burst(800);
    drain_and_wait();

    $display("Run covered %0d results: %0d grants and %0d frees over several heap limits.",
             rsp_count, alloc_ok_count, free_ok_count);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
